@@ rtl/core/imsu_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// Shared types and constants of the Ising Metropolis site update block.
// No dependencies; used by the channel interfaces and the top level.

package imsu_pkg;

    localparam int SIDE_DEFAULT = 64;

    localparam int OPCODE_W = 1;
    localparam int COORD_W  = 6;
    localparam int FRAC_W   = 16;
    localparam int MAG_W    = 14;
    localparam int THR_W    = 17;
    localparam int THR_NUM  = 5;
    localparam int THR_LO_W = 51;
    localparam int THR_HI_W = 34;

    localparam int CFG_ADDR_W = 5;
    localparam int CFG_DATA_W = 64;

    localparam logic signed [MAG_W-1:0] MAG_STEP = 14'sd2;

    typedef logic [THR_W-1:0] t_thr;
    typedef logic [2:0]       t_nbr_cnt;

    typedef enum logic [OPCODE_W-1:0] {
        OP_ATTEMPT = 1'b0,
        OP_WRITE   = 1'b1
    } t_opcode;

    typedef enum logic [1:0] {
        REG_UP_LO   = 2'd0,
        REG_UP_HI   = 2'd1,
        REG_DOWN_LO = 2'd2,
        REG_DOWN_HI = 2'd3
    } t_reg_idx;

    typedef enum logic [2:0] {
        ST_CLEAR = 3'b001,
        ST_IDLE  = 3'b010,
        ST_EXEC  = 3'b100
    } t_state;

endpackage

`default_nettype wire

@@ rtl/core/imsu_in_if.sv @@
`timescale 1ns / 1ps
`default_nettype none
// Update item channel: valid/ready handshake plus update payload.
// Depends on imsu_pkg.

interface imsu_in_if;
    logic                              valid;
    logic                              ready;
    logic [imsu_pkg::OPCODE_W-1:0]     opcode;
    logic [imsu_pkg::COORD_W-1:0]      row;
    logic [imsu_pkg::COORD_W-1:0]      column;
    logic [imsu_pkg::FRAC_W-1:0]       random_fraction;
    logic                              write_spin;

    modport source (output valid, opcode, row, column, random_fraction, write_spin,
                    input ready);
    modport sink   (input valid, opcode, row, column, random_fraction, write_spin,
                    output ready);
endinterface

`default_nettype wire

@@ rtl/core/imsu_out_if.sv @@
`timescale 1ns / 1ps
`default_nettype none
// Result channel: valid/ready handshake plus spin, flip flag and magnetization.
// Depends on imsu_pkg.

interface imsu_out_if;
    logic                              valid;
    logic                              ready;
    logic                              spin_after;
    logic                              flipped;
    logic signed [imsu_pkg::MAG_W-1:0] magnetization;

    modport source (output valid, spin_after, flipped, magnetization, input ready);
    modport sink   (input valid, spin_after, flipped, magnetization, output ready);
endinterface

`default_nettype wire

@@ rtl/core/ising_metropolis_site_update_top.sv @@
`timescale 1ns / 1ps
`default_nettype none
// Ising lattice Metropolis site update: row-wide spin memories, update FSM, APB regs.
// Depends on imsu_pkg, imsu_in_if, imsu_out_if.
//
//  channel  | dir | beat                                               | handshake
//  i_upd    | in  | opcode, row, column, random_fraction, write_spin   | valid/ready
//  o_res    | out | spin_after, flipped, magnetization                 | valid/ready
//  apb      | in  | 4 threshold registers at 8*i, 64-bit data          | psel/penable
//
// Each beat: on accept the rows above, below and at the site are registered from the
// two row-wide memory copies; in EXEC the block decides and writes the row back.
// After reset a clear pass sets every spin up; i_upd.ready is low during it.
// A full result register stalls the write-back cycle until o_res is taken;
// a new beat is accepted while a result waits.

module ising_metropolis_site_update_top #(
    parameter int SIDE = imsu_pkg::SIDE_DEFAULT
) (
    input  wire                               i_clk,
    input  wire                               i_rst_n,
    imsu_in_if.sink                           i_upd,
    imsu_out_if.source                        o_res,
    input  wire                               psel,
    input  wire                               penable,
    input  wire                               pwrite,
    input  wire [imsu_pkg::CFG_ADDR_W-1:0]    paddr,
    input  wire [imsu_pkg::CFG_DATA_W-1:0]    pwdata,
    output logic [imsu_pkg::CFG_DATA_W-1:0]   prdata,
    output logic                              pready
);

    localparam int RW   = $clog2(SIDE);
    localparam int MW   = (RW > imsu_pkg::COORD_W) ? RW : imsu_pkg::COORD_W;
    localparam int QMAX = ((1 << imsu_pkg::COORD_W) - 1) / SIDE;
    localparam logic [imsu_pkg::MAG_W-1:0] MAG_RESET = imsu_pkg::MAG_W'(SIDE * SIDE);

    // spin rows: copy a serves the rows above and below, copy b the site row
    logic [SIDE-1:0] r_mem_a [SIDE];
    logic [SIDE-1:0] r_mem_b [SIDE];
    logic [SIDE-1:0] r_rd_up, r_rd_dn, r_rd_ctr;

    imsu_pkg::t_state r_state, n_state;
    logic [RW-1:0]    r_clr_row;

    logic [imsu_pkg::THR_LO_W-1:0] r_up_lo, r_down_lo;
    logic [imsu_pkg::THR_HI_W-1:0] r_up_hi, r_down_hi;

    logic                          r_op;
    logic [RW-1:0]                 r_row, r_col;
    logic [imsu_pkg::FRAC_W-1:0]   r_frac;
    logic                          r_wspin;

    logic signed [imsu_pkg::MAG_W-1:0] r_mag, n_mag;
    logic                              r_out_valid;
    logic                              r_out_spin, r_out_flip;
    logic signed [imsu_pkg::MAG_W-1:0] r_out_mag;

    logic [RW-1:0] in_row, in_col, in_row_up, in_row_dn;
    logic [RW-1:0] col_l, col_r;
    logic          accept, exec_go, cfg_wr, mem_we;
    logic [RW-1:0] mem_waddr;
    logic [SIDE-1:0] mem_wdata, n_row_word;
    logic          spin_now, spin_new, changed, flip;
    imsu_pkg::t_nbr_cnt nbr_up;
    imsu_pkg::t_thr     thr_up [imsu_pkg::THR_NUM];
    imsu_pkg::t_thr     thr_dn [imsu_pkg::THR_NUM];
    imsu_pkg::t_thr     thr;
    imsu_pkg::t_reg_idx reg_idx;

    // coordinates modulo SIDE
    always_comb begin
        in_row = '0;
        in_col = '0;
        for (int q = 0; q <= QMAX; q++) begin
            if (int'(i_upd.row) >= q * SIDE && int'(i_upd.row) < (q + 1) * SIDE) begin
                in_row = in_row | RW'(MW'(i_upd.row) - MW'(q * SIDE));
            end
            if (int'(i_upd.column) >= q * SIDE && int'(i_upd.column) < (q + 1) * SIDE) begin
                in_col = in_col | RW'(MW'(i_upd.column) - MW'(q * SIDE));
            end
        end
    end

    assign in_row_up = (in_row == '0) ? RW'(SIDE - 1) : in_row - RW'(1);
    assign in_row_dn = (in_row == RW'(SIDE - 1)) ? '0 : in_row + RW'(1);
    assign col_l     = (r_col == '0) ? RW'(SIDE - 1) : r_col - RW'(1);
    assign col_r     = (r_col == RW'(SIDE - 1)) ? '0 : r_col + RW'(1);

    assign i_upd.ready = (r_state == imsu_pkg::ST_IDLE);
    assign accept      = i_upd.valid && i_upd.ready;
    assign exec_go     = (r_state == imsu_pkg::ST_EXEC) && (!r_out_valid || o_res.ready);

    // decision
    always_comb begin
        thr_up[0] = r_up_lo[16:0];
        thr_up[1] = r_up_lo[33:17];
        thr_up[2] = r_up_lo[50:34];
        thr_up[3] = r_up_hi[16:0];
        thr_up[4] = r_up_hi[33:17];
        thr_dn[0] = r_down_lo[16:0];
        thr_dn[1] = r_down_lo[33:17];
        thr_dn[2] = r_down_lo[50:34];
        thr_dn[3] = r_down_hi[16:0];
        thr_dn[4] = r_down_hi[33:17];
    end

    assign spin_now = r_rd_ctr[r_col];
    assign nbr_up   = imsu_pkg::t_nbr_cnt'(r_rd_ctr[col_l]) + imsu_pkg::t_nbr_cnt'(r_rd_ctr[col_r])
                    + imsu_pkg::t_nbr_cnt'(r_rd_up[r_col]) + imsu_pkg::t_nbr_cnt'(r_rd_dn[r_col]);
    assign thr      = spin_now ? thr_up[nbr_up] : thr_dn[nbr_up];
    assign flip     = {1'b0, r_frac} < thr;
    assign spin_new = (r_op == imsu_pkg::OP_WRITE) ? r_wspin : (spin_now ^ flip);
    assign changed  = spin_new != spin_now;
    assign n_mag    = !changed ? r_mag
                    : (spin_new ? r_mag + imsu_pkg::MAG_STEP : r_mag - imsu_pkg::MAG_STEP);

    always_comb begin
        n_row_word        = r_rd_ctr;
        n_row_word[r_col] = spin_new;
    end

    assign mem_we    = (r_state == imsu_pkg::ST_CLEAR) || exec_go;
    assign mem_waddr = (r_state == imsu_pkg::ST_CLEAR) ? r_clr_row : r_row;
    assign mem_wdata = (r_state == imsu_pkg::ST_CLEAR) ? '1 : n_row_word;

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem_a[mem_waddr] <= mem_wdata;
            r_mem_b[mem_waddr] <= mem_wdata;
        end
        if (accept) begin
            r_rd_up  <= r_mem_a[in_row_up];
            r_rd_dn  <= r_mem_a[in_row_dn];
            r_rd_ctr <= r_mem_b[in_row];
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_op    <= i_upd.opcode;
            r_row   <= in_row;
            r_col   <= in_col;
            r_frac  <= i_upd.random_fraction;
            r_wspin <= i_upd.write_spin;
        end
        if (exec_go) begin
            r_out_spin <= spin_new;
            r_out_flip <= changed;
            r_out_mag  <= n_mag;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            imsu_pkg::ST_CLEAR: begin
                if (r_clr_row == RW'(SIDE - 1)) n_state = imsu_pkg::ST_IDLE;
            end
            imsu_pkg::ST_IDLE: begin
                if (accept) n_state = imsu_pkg::ST_EXEC;
            end
            imsu_pkg::ST_EXEC: begin
                if (exec_go) n_state = imsu_pkg::ST_IDLE;
            end
            default: n_state = imsu_pkg::ST_CLEAR;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= imsu_pkg::ST_CLEAR;
            r_clr_row   <= '0;
            r_mag       <= MAG_RESET;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == imsu_pkg::ST_CLEAR) r_clr_row <= r_clr_row + RW'(1);
            if (exec_go) begin
                r_mag       <= n_mag;
                r_out_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_res.valid         = r_out_valid;
    assign o_res.spin_after    = r_out_spin;
    assign o_res.flipped       = r_out_flip;
    assign o_res.magnetization = r_out_mag;

    // APB registers
    assign pready  = 1'b1;
    assign reg_idx = imsu_pkg::t_reg_idx'(paddr[4:3]);
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_up_lo   <= '0;
            r_up_hi   <= '0;
            r_down_lo <= '0;
            r_down_hi <= '0;
        end else if (cfg_wr) begin
            unique case (reg_idx)
                imsu_pkg::REG_UP_LO:   r_up_lo   <= pwdata[imsu_pkg::THR_LO_W-1:0];
                imsu_pkg::REG_UP_HI:   r_up_hi   <= pwdata[imsu_pkg::THR_HI_W-1:0];
                imsu_pkg::REG_DOWN_LO: r_down_lo <= pwdata[imsu_pkg::THR_LO_W-1:0];
                imsu_pkg::REG_DOWN_HI: r_down_hi <= pwdata[imsu_pkg::THR_HI_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            imsu_pkg::REG_UP_LO:   prdata = imsu_pkg::CFG_DATA_W'(r_up_lo);
            imsu_pkg::REG_UP_HI:   prdata = imsu_pkg::CFG_DATA_W'(r_up_hi);
            imsu_pkg::REG_DOWN_LO: prdata = imsu_pkg::CFG_DATA_W'(r_down_lo);
            imsu_pkg::REG_DOWN_HI: prdata = imsu_pkg::CFG_DATA_W'(r_down_hi);
            default:               prdata = '0;
        endcase
    end

endmodule

`default_nettype wire
